>>> rtl/sacl_pkg.sv
// shared constants, types and codes of the set-associative lru cache model
// no dependencies; imported by every rtl module of the block
package sacl_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_WIDTH   = 64;
    localparam int AGE_WIDTH    = 32;
    localparam int CNT_WIDTH    = 32;

    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NWAY_W    = $clog2(MAX_WAYS + 1);
    localparam int TREE_N    = 1 << WAY_W;
    localparam int SHIFT_W   = $clog2(ADDR_WIDTH + 1 + (1 << 3));

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // access commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;
    localparam logic [1:0] CMD_FETCH  = 2'd3;

    typedef struct packed {
        logic                  valid;
        logic [ADDR_WIDTH-1:0] tag;
        logic [AGE_WIDTH-1:0]  age;
    } t_way;

    typedef t_way [MAX_WAYS-1:0] t_row;

    typedef struct packed {
        logic hit;
        logic evicted;
        t_row row;
    } t_lookup;

endpackage

>>> rtl/sacl_set_ram.sv
// set memory: one row of all ways per set, registered read, one write port
// row valid flip-flops make never-written rows read as all zero after reset
// depends on sacl_pkg
module sacl_set_ram
    import sacl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [SET_W-1:0] i_rd_addr,
    output t_row             o_rd_data,
    input  logic             i_wr_en,
    input  logic [SET_W-1:0] i_wr_addr,
    input  t_row             i_wr_data
);

    t_row              mem [NUM_SETS];
    logic [NUM_SETS-1:0] r_row_valid;
    t_row              r_rd_data;
    logic              r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_row_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

>>> rtl/sacl_lookup.sv
// tag compare, fill/victim choice and age update for one set row
// depends on sacl_pkg
module sacl_lookup
    import sacl_pkg::*;
(
    input  t_row                  i_row,
    input  logic [ADDR_WIDTH-1:0] i_tag,
    input  logic [NWAY_W-1:0]     i_nways,
    output t_lookup               o_res
);

    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] match;
    logic                has_free;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    sel_way;
    logic [AGE_WIDTH-1:0] node_age [2*TREE_N-1];
    logic [WAY_W-1:0]     node_idx [2*TREE_N-1];

    always_comb begin
        has_free = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int j = 0; j < MAX_WAYS; j++) begin
            in_use[j] = (j < int'(i_nways));
            match[j]  = in_use[j] && i_row[j].valid && (i_row[j].tag == i_tag);
        end
        // lowest matching way wins
        for (int j = MAX_WAYS - 1; j >= 0; j--) begin
            if (match[j]) begin
                hit_way = WAY_W'(j);
            end
        end
        // highest invalid way wins
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (in_use[j] && !i_row[j].valid) begin
                has_free = 1'b1;
                free_way = WAY_W'(j);
            end
        end
        // oldest way by a compare tree, left side wins a tie
        for (int k = 0; k < MAX_WAYS; k++) begin
            node_age[TREE_N-1+k] = in_use[k] ? i_row[k].age : '0;
            node_idx[TREE_N-1+k] = WAY_W'(k);
        end
        for (int k = MAX_WAYS; k < TREE_N; k++) begin
            node_age[TREE_N-1+k] = '0;
            node_idx[TREE_N-1+k] = WAY_W'(k);
        end
        for (int i = TREE_N - 2; i >= 0; i--) begin
            if (node_age[2*i+2] > node_age[2*i+1]) begin
                node_age[i] = node_age[2*i+2];
                node_idx[i] = node_idx[2*i+2];
            end else begin
                node_age[i] = node_age[2*i+1];
                node_idx[i] = node_idx[2*i+1];
            end
        end

        o_res.hit     = |match;
        o_res.evicted = !(|match) && !has_free;
        if (|match) begin
            sel_way = hit_way;
        end else if (has_free) begin
            sel_way = free_way;
        end else begin
            sel_way = node_idx[0];
        end

        o_res.row = i_row;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (in_use[j]) begin
                if (WAY_W'(j) == sel_way) begin
                    o_res.row[j].valid = 1'b1;
                    o_res.row[j].tag   = i_tag;
                    o_res.row[j].age   = '0;
                end else if (i_row[j].age != {AGE_WIDTH{1'b1}}) begin
                    o_res.row[j].age = i_row[j].age + AGE_WIDTH'(1);
                end
            end
        end
    end

endmodule

>>> rtl/set_assoc_cache_lru_model.sv
// set-associative cache model with lru replacement and hit/miss/evict totals
// load/store: result registered after the set-row read and the eval; eval waits while the output is held
// modify: two results, from an eval, a re-read of the set and a second eval; fetch: taken, no result
// each pass is one set-row read from the set ram and one eval step that writes it back
// synchronous active-low reset clears the row valid flops at once, so no clearing pass
// depends on sacl_pkg, sacl_set_ram, sacl_lookup
module set_assoc_cache_lru_model
    import sacl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_command,
    input  logic [ADDR_WIDTH-1:0] i_address,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_hit,
    output logic                  o_miss,
    output logic                  o_evicted,
    output logic [CNT_WIDTH-1:0]  o_hit_total,
    output logic [CNT_WIDTH-1:0]  o_miss_total,
    output logic [CNT_WIDTH-1:0]  o_evict_total,
    output logic                  o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0]            r_state;
    logic [2:0]            r_set_bits;
    logic [5:0]            r_block_bits;
    logic [3:0]            r_ways;
    logic [SET_W-1:0]      r_set;
    logic [ADDR_WIDTH-1:0] r_tag;
    logic                  r_second;
    logic [CNT_WIDTH-1:0]  r_hits;
    logic [CNT_WIDTH-1:0]  r_misses;
    logic [CNT_WIDTH-1:0]  r_evicts;
    logic [CNT_WIDTH-1:0]  n_hits;
    logic [CNT_WIDTH-1:0]  n_misses;
    logic [CNT_WIDTH-1:0]  n_evicts;

    logic [2:0]            sb_eff;
    logic [NWAY_W-1:0]     nways;
    logic [ADDR_WIDTH-1:0] set_mask;
    logic [ADDR_WIDTH-1:0] set_full;
    logic [6:0]            tag_shift;
    logic [ADDR_WIDTH-1:0] tag_comb;
    logic                  in_xfer;
    logic                  start;
    logic                  out_free;
    logic                  eval_fire;
    logic                  rd_en;
    logic [SET_W-1:0]      rd_addr;
    t_row                  rd_row;
    t_lookup               lk;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign start       = in_xfer && (i_command != CMD_FETCH);
    assign out_free    = !o_out_valid || i_out_ready;
    assign eval_fire   = (r_state == ST_EVAL) && out_free;

    // address split from the live configuration
    always_comb begin
        sb_eff = (int'(r_set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : r_set_bits;
        if (r_ways == 4'd0) begin
            nways = NWAY_W'(1);
        end else if (int'(r_ways) > MAX_WAYS) begin
            nways = NWAY_W'(MAX_WAYS);
        end else begin
            nways = NWAY_W'(r_ways);
        end
        set_mask  = (ADDR_WIDTH'(1) << sb_eff) - ADDR_WIDTH'(1);
        set_full  = (i_address >> r_block_bits) & set_mask;
        tag_shift = {1'b0, r_block_bits} + {4'd0, sb_eff};
        tag_comb  = (int'(tag_shift) >= ADDR_WIDTH) ? '0 : (i_address >> tag_shift);
    end

    assign rd_en   = start || (r_state == ST_READ);
    assign rd_addr = (r_state == ST_READ) ? r_set : set_full[SET_W-1:0];

    sacl_set_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_row),
        .i_wr_en   (eval_fire),
        .i_wr_addr (r_set),
        .i_wr_data (lk.row)
    );

    sacl_lookup u_lookup (
        .i_row   (rd_row),
        .i_tag   (r_tag),
        .i_nways (nways),
        .o_res   (lk)
    );

    assign n_hits   = r_hits + CNT_WIDTH'(lk.hit);
    assign n_misses = r_misses + CNT_WIDTH'(!lk.hit);
    assign n_evicts = r_evicts + CNT_WIDTH'(lk.evicted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_set_bits   <= 3'd0;
            r_block_bits <= 6'd0;
            r_ways       <= 4'd1;
            r_second     <= 1'b0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_evicts     <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SET_BITS:    r_set_bits   <= i_cfg_data[2:0];
                    CFG_BLOCK_BITS:  r_block_bits <= i_cfg_data[5:0];
                    CFG_WAYS_IN_USE: r_ways       <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            if (eval_fire) begin
                o_out_valid <= 1'b1;
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_evicts    <= n_evicts;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_second <= (i_command == CMD_MODIFY);
                        r_state  <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (eval_fire) begin
                        r_second <= 1'b0;
                        r_state  <= r_second ? ST_READ : ST_IDLE;
                    end
                end
                ST_READ: begin
                    r_state <= ST_EVAL;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_set <= set_full[SET_W-1:0];
            r_tag <= tag_comb;
        end
        if (eval_fire) begin
            o_hit         <= lk.hit;
            o_miss        <= !lk.hit;
            o_evicted     <= lk.evicted;
            o_hit_total   <= n_hits;
            o_miss_total  <= n_misses;
            o_evict_total <= n_evicts;
            o_last        <= !r_second;
        end
    end

    a_modify_two_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_command == CMD_MODIFY) |=> (r_state == ST_EVAL && r_second))
        else $error("modify did not arm a second pass");

    a_first_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |-> (r_state != ST_IDLE))
        else $error("block idle before second result of a modify");

    a_outcome_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_hit ^ o_miss) && !(o_evicted && o_hit)))
        else $error("inconsistent hit/miss/evict flags");

    a_one_count_per_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eval_fire |=> ((r_hits + r_misses) == ($past(r_hits + r_misses) + CNT_WIDTH'(1))))
        else $error("access not counted exactly once");

    a_fetch_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_command == CMD_FETCH) |=> (r_state == ST_IDLE && $stable(r_hits)))
        else $error("fetch changed state");

endmodule
